FILE: rtl/core/pcxrle_pkg.sv
`default_nettype none

package pcxrle_pkg;

  typedef enum logic [1:0] {
    OP_PAL_WRITE  = 2'd0,
    OP_IMAGE_BYTE = 2'd1,
    OP_END_DATA   = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_LEFT_EDGE   = 3'd0;
  localparam cfg_idx_t CFG_RIGHT_EDGE  = 3'd1;
  localparam cfg_idx_t CFG_TOP_EDGE    = 3'd2;
  localparam cfg_idx_t CFG_BOTTOM_EDGE = 3'd3;

  localparam logic [7:0] RUN_FLAG_MASK  = 8'hC0;
  localparam logic [7:0] RUN_COUNT_MASK = 8'h3F;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RUN    = 3'b010,
    S_STATUS = 3'b100
  } state_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  idx;
    logic [23:0] rgb;
  } pal_wr_t;

  typedef struct packed {
    logic       en;
    logic [7:0] idx;
  } pal_rd_t;

endpackage

`default_nettype wire

FILE: rtl/core/pcx_rle_palette_decoder_unit.sv
// A pixel's colour goes from the registered palette port to the output register.
// Palette writes and run headers never stall the input; a single pixel byte or
// run value byte reads the palette and stalls the input while its pixels go out,
// one per cycle unless the output stalls. End of data: one status result.
// Reset (rst_n low, synchronous): edges 0, cursor at origin, no pending run;
// palette contents are kept and undefined until written.
`default_nettype none

module pcx_rle_palette_decoder_unit
  import pcxrle_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_we,
  input  wire cfg_idx_t    cfg_index,
  input  wire logic [15:0] cfg_data,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [7:0]  in_palette_index,
  input  wire logic [7:0]  in_red_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_blue_in,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_pixel_x,
  output logic [15:0]      out_pixel_y,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_run_last,
  output logic             out_image_done,
  output logic             out_is_status,
  output logic             out_truncated
);

  state_t      state_r, state_nxt;
  logic [15:0] left_r, left_nxt, right_r, right_nxt;
  logic [15:0] top_r, top_nxt, bottom_r, bottom_nxt;
  logic [15:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic        await_r, await_nxt;
  logic [5:0]  pend_r, pend_nxt;
  logic        complete_r, complete_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        trunc_r, trunc_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [23:0] out_rgb_r, out_rgb_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_done_r, out_done_nxt;
  logic        out_status_r, out_status_nxt;
  logic        out_trunc_r, out_trunc_nxt;

  pal_wr_t     pal_wr;
  pal_rd_t     pal_rd;
  logic [23:0] pal_data;

  logic        in_acc;
  logic        finished;
  logic        out_free;
  logic        line_end;
  logic        last_px;

  pcxrle_palette #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr      (pal_wr),
    .rd      (pal_rd),
    .rd_data (pal_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign finished = complete_r || (right_r < left_r) || (bottom_r < top_r);
  assign out_free = !out_valid_r || !out_stall;
  assign line_end = (cur_x_r == right_r);
  assign last_px  = line_end || (cnt_r == 6'd1);

  always_comb begin
    state_nxt      = state_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    top_nxt        = top_r;
    bottom_nxt     = bottom_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    await_nxt      = await_r;
    pend_nxt       = pend_r;
    complete_nxt   = complete_r;
    cnt_nxt        = cnt_r;
    trunc_nxt      = trunc_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_rgb_nxt    = out_rgb_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;
    out_status_nxt = out_status_r;
    out_trunc_nxt  = out_trunc_r;
    pal_wr         = '0;
    pal_rd         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_operation))
            OP_PAL_WRITE: begin
              pal_wr = '{en: 1'b1, idx: in_palette_index,
                         rgb: {in_red_in, in_green_in, in_blue_in}};
            end
            OP_IMAGE_BYTE: begin
              if (!finished) begin
                if (await_r) begin
                  await_nxt = 1'b0;
                  pend_nxt  = '0;
                  if (pend_r != '0) begin
                    pal_rd    = '{en: 1'b1, idx: in_data_byte};
                    cnt_nxt   = pend_r;
                    state_nxt = S_RUN;
                  end
                end else if ((in_data_byte & RUN_FLAG_MASK) == RUN_FLAG_MASK) begin
                  await_nxt = 1'b1;
                  pend_nxt  = 6'(in_data_byte & RUN_COUNT_MASK);
                end else begin
                  pal_rd    = '{en: 1'b1, idx: in_data_byte};
                  cnt_nxt   = 6'd1;
                  state_nxt = S_RUN;
                end
              end
            end
            OP_END_DATA: begin
              trunc_nxt    = !finished;
              cur_x_nxt    = left_r;
              cur_y_nxt    = top_r;
              await_nxt    = 1'b0;
              pend_nxt     = '0;
              complete_nxt = 1'b0;
              state_nxt    = S_STATUS;
            end
            default: begin
            end
          endcase
        end
      end
      S_RUN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_x_nxt      = cur_x_r;
          out_y_nxt      = cur_y_r;
          out_rgb_nxt    = pal_data;
          out_last_nxt   = last_px;
          out_done_nxt   = line_end && (cur_y_r == bottom_r);
          out_status_nxt = 1'b0;
          out_trunc_nxt  = 1'b0;
          cnt_nxt        = cnt_r - 6'd1;
          if (line_end) begin
            cur_x_nxt = left_r;
            if (cur_y_r == bottom_r) begin
              complete_nxt = 1'b1;
            end else begin
              cur_y_nxt = cur_y_r + 16'd1;
            end
          end else begin
            cur_x_nxt = cur_x_r + 16'd1;
          end
          if (last_px) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_STATUS: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_x_nxt      = '0;
          out_y_nxt      = '0;
          out_rgb_nxt    = '0;
          out_last_nxt   = 1'b1;
          out_done_nxt   = 1'b0;
          out_status_nxt = 1'b1;
          out_trunc_nxt  = trunc_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we && (cfg_index <= CFG_BOTTOM_EDGE)) begin
      case (cfg_index)
        CFG_LEFT_EDGE:   left_nxt   = cfg_data;
        CFG_RIGHT_EDGE:  right_nxt  = cfg_data;
        CFG_TOP_EDGE:    top_nxt    = cfg_data;
        CFG_BOTTOM_EDGE: bottom_nxt = cfg_data;
        default: begin
        end
      endcase
      cur_x_nxt    = left_nxt;
      cur_y_nxt    = top_nxt;
      await_nxt    = 1'b0;
      pend_nxt     = '0;
      complete_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      left_r      <= '0;
      right_r     <= '0;
      top_r       <= '0;
      bottom_r    <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      await_r     <= 1'b0;
      pend_r      <= '0;
      complete_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      top_r       <= top_nxt;
      bottom_r    <= bottom_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      await_r     <= await_nxt;
      pend_r      <= pend_nxt;
      complete_r  <= complete_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    trunc_r      <= trunc_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_rgb_r    <= out_rgb_nxt;
    out_last_r   <= out_last_nxt;
    out_done_r   <= out_done_nxt;
    out_status_r <= out_status_nxt;
    out_trunc_r  <= out_trunc_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = out_x_r;
  assign out_pixel_y    = out_y_r;
  assign out_red_out    = out_rgb_r[23:16];
  assign out_green_out  = out_rgb_r[15:8];
  assign out_blue_out   = out_rgb_r[7:0];
  assign out_run_last   = out_last_r;
  assign out_image_done = out_done_r;
  assign out_is_status  = out_status_r;
  assign out_truncated  = out_trunc_r;

  // a run in flight always has pixels left
  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (cnt_r != '0))
    else $error("run state with zero count");

  // no pixels once the frame is complete
  a_run_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> !complete_r)
    else $error("run state after frame completion");

  // completing pixel closes its run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> out_last_r)
    else $error("image_done without run_last");

  // a run step with a free output puts a pixel in the output register on the next cycle
  a_pixel_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && out_free) |=> (out_valid_r && !out_status_r))
    else $error("pixel not loaded into output register");

endmodule

`default_nettype wire

FILE: rtl/core/pcxrle_palette.sv
`default_nettype none

module pcxrle_palette
  import pcxrle_pkg::*;
#(
  parameter int unsigned ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire pal_wr_t     wr,
  input  wire pal_rd_t     rd,
  output logic [23:0]      rd_data
);

  localparam int unsigned AW = $clog2(ENTRIES);

  logic [23:0] mem [ENTRIES];
  logic [23:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx[AW-1:0]] <= wr.rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.idx[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
